>>> design/csvtok_pkg.sv
// csvtok_pkg: shared types, character and code constants for the csv tokenizer
// used by every module of csv_field_tokenizer_unit; no dependencies
`timescale 1ns / 1ps

package csvtok_pkg;

  // characters that steer the tokenizer
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // result kinds
  localparam logic [2:0] KIND_BYTE  = 3'd0;
  localparam logic [2:0] KIND_FIELD = 3'd1;
  localparam logic [2:0] KIND_ROW   = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_AFTER_CLOSE = 3'd1;
  localparam logic [2:0] ERR_STRAY_QUOTE = 3'd2;
  localparam logic [2:0] ERR_UNTERM      = 3'd3;
  localparam logic [2:0] ERR_EMPTY       = 3'd4;

  // most results one input beat can cause
  localparam int MAX_RES = 3;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
    logic       in_valid;
  } in_t;

  typedef struct packed {
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic [2:0] err_code;
    logic       run_last;
  } out_t;

  // group of results from one input beat
  typedef struct packed {
    logic [1:0]           cnt;
    out_t [MAX_RES-1:0]   res;
  } grp_t;

  // parser flags
  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic closed_quote;
    logic field_begun;
    logic row_has_fields;
    logic cr_pending;
    logic any_row_seen;
    logic error_seen;
  } st_t;

  // build one result entry
  function automatic out_t mk_res(input logic [2:0] kind, input logic [7:0] b,
                                  input logic [2:0] err);
    out_t r;
    r.out_kind = kind;
    r.out_byte = b;
    r.err_code = err;
    r.run_last = 1'b0;
    return r;
  endfunction

endpackage

>>> design/csvtok_front.sv
// csvtok_front: accepts input beats, runs the parser flags and forms result groups
// depends on csvtok_pkg
`timescale 1ns / 1ps

module csvtok_front import csvtok_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  input  logic q_full,
  output logic push,
  output grp_t push_grp
);

  st_t        st_r;
  st_t        st_nxt;
  grp_t       grp;
  logic [1:0] n;
  logic       skip;
  logic       do_plain;
  logic [7:0] b;
  logic       acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign b        = in_data.in_byte;

  // parse one beat: byte first, then end of input
  always_comb begin
    st_nxt   = st_r;
    grp      = '0;
    n        = 2'd0;
    skip     = 1'b0;
    do_plain = 1'b0;

    if (in_data.in_valid && !st_r.error_seen) begin
      if (st_r.cr_pending) begin
        st_nxt.cr_pending = 1'b0;
        if (b == CH_LF) begin
          skip = 1'b1;
        end
      end
      if (!skip) begin
        if (st_r.quote_pending) begin
          st_nxt.quote_pending = 1'b0;
          if (b == CH_QUOTE) begin
            grp.res[n] = mk_res(KIND_BYTE, CH_QUOTE, ERR_NONE);
            n = n + 2'd1;
          end else begin
            st_nxt.in_quotes    = 1'b0;
            st_nxt.closed_quote = 1'b1;
            do_plain            = 1'b1;
          end
        end else if (st_r.in_quotes) begin
          if (b == CH_QUOTE) begin
            st_nxt.quote_pending = 1'b1;
          end else begin
            grp.res[n] = mk_res(KIND_BYTE, b, ERR_NONE);
            n = n + 2'd1;
          end
        end else begin
          do_plain = 1'b1;
        end
      end

      // byte outside quotes
      if (do_plain) begin
        if (st_nxt.closed_quote && b != CH_COMMA && b != CH_CR && b != CH_LF) begin
          grp.res[n] = mk_res(KIND_ERR, 8'h00, ERR_AFTER_CLOSE);
          n = n + 2'd1;
          st_nxt.error_seen = 1'b1;
        end else if (b == CH_QUOTE) begin
          if (st_nxt.field_begun) begin
            grp.res[n] = mk_res(KIND_ERR, 8'h00, ERR_STRAY_QUOTE);
            n = n + 2'd1;
            st_nxt.error_seen = 1'b1;
          end else begin
            st_nxt.in_quotes   = 1'b1;
            st_nxt.field_begun = 1'b1;
          end
        end else if (b == CH_COMMA) begin
          grp.res[n] = mk_res(KIND_FIELD, 8'h00, ERR_NONE);
          n = n + 2'd1;
          st_nxt.row_has_fields = 1'b1;
          st_nxt.field_begun    = 1'b0;
          st_nxt.closed_quote   = 1'b0;
        end else if (b == CH_LF || b == CH_CR) begin
          grp.res[n] = mk_res(KIND_ROW, 8'h00, ERR_NONE);
          n = n + 2'd1;
          st_nxt.any_row_seen   = 1'b1;
          st_nxt.row_has_fields = 1'b0;
          st_nxt.field_begun    = 1'b0;
          st_nxt.closed_quote   = 1'b0;
          st_nxt.cr_pending     = (b == CH_CR);
        end else begin
          grp.res[n] = mk_res(KIND_BYTE, b, ERR_NONE);
          n = n + 2'd1;
          st_nxt.field_begun = 1'b1;
        end
      end
    end

    // end of input: close what is open, then input end and back to reset
    if (in_data.in_end) begin
      if (!st_nxt.error_seen) begin
        if (st_nxt.quote_pending) begin
          st_nxt.quote_pending = 1'b0;
          st_nxt.in_quotes     = 1'b0;
          st_nxt.closed_quote  = 1'b1;
        end
        if (st_nxt.in_quotes) begin
          grp.res[n] = mk_res(KIND_ERR, 8'h00, ERR_UNTERM);
          n = n + 2'd1;
        end else begin
          if (st_nxt.row_has_fields || st_nxt.field_begun) begin
            grp.res[n] = mk_res(KIND_ROW, 8'h00, ERR_NONE);
            n = n + 2'd1;
            st_nxt.any_row_seen = 1'b1;
          end
          if (!st_nxt.any_row_seen) begin
            grp.res[n] = mk_res(KIND_ERR, 8'h00, ERR_EMPTY);
            n = n + 2'd1;
          end
        end
      end
      if (n != 2'd3) begin
        grp.res[n] = mk_res(KIND_END, 8'h00, ERR_NONE);
        n = n + 2'd1;
      end
      st_nxt = '0;
    end

    // flag the last result of this beat
    if (n != 2'd0) begin
      grp.res[n - 2'd1].run_last = 1'b1;
    end
    grp.cnt = n;
  end

  assign push     = acc && (n != 2'd0);
  assign push_grp = grp;

  // parser flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> design/csvtok_queue.sv
// csvtok_queue: small first-in first-out queue of result groups between front and back
// depends on csvtok_pkg
`timescale 1ns / 1ps

module csvtok_queue import csvtok_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_grp,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output grp_t head_grp
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  grp_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] wr_nxt;
  logic [PW-1:0] rd_r;
  logic [PW-1:0] rd_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (cnt_r == CW'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_grp   = slot_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer wrap
  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_grp;
    end
  end

endmodule

>>> design/csvtok_back.sv
// csvtok_back: walks each result group and sends one result beat per cycle while the
// receiver does not stall, through an output register; depends on csvtok_pkg
`timescale 1ns / 1ps

module csvtok_back import csvtok_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  grp_t head_grp,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_t       out_data_r;
  logic       load;

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && (idx_r == head_grp.cnt - 2'd1);

  // next result index and output register state
  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = pop ? 2'd0 : idx_r + 2'd1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= head_grp.res[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/csv_field_tokenizer_unit.sv
// Streaming CSV tokenizer, one input beat per byte with an end-of-input flag. Each
// beat gives zero to three result beats: field bytes with quotes removed, field end,
// row end, input end and error. The front takes one input beat per cycle while the
// queue of result groups has room; the back sends one result beat per cycle while the
// receiver does not stall, so a beat that causes k results takes k output beats.
// Results pass through the group queue and the output register. After an error, bytes are
// dropped until the end beat, and every end beat returns the parser to its reset state.
// depends on csvtok_pkg, csvtok_front, csvtok_queue, csvtok_back
`timescale 1ns / 1ps

module csv_field_tokenizer_unit import csvtok_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic q_full;
  logic push;
  grp_t push_grp;
  logic pop;
  logic head_valid;
  grp_t head_grp;

  // parser front
  csvtok_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_grp (push_grp)
  );

  // group queue
  csvtok_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_grp   (push_grp),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_grp   (head_grp)
  );

  // result back
  csvtok_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_grp   (head_grp),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> test/csv_field_tokenizer_unit_tb.sv
// csv_field_tokenizer_unit_tb: drives csv byte streams into the tokenizer and checks every
// result beat against a local tokenizer predictor kept in a small scoreboard class
// depends on csvtok_pkg and the csv_field_tokenizer_unit rtl
`timescale 1ns / 1ps

module csv_field_tokenizer_unit_tb;
  import csvtok_pkg::*;

  localparam int RANDOM_ITEMS = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  // scoreboard: tokenizer predictor plus the queue of expected result beats
  class tok_scoreboard;
    bit   in_quoted, quote_held, quote_closed, field_open;
    bit   row_open, skip_lf, saw_row, halted;
    out_t beat_tokens[$];
    out_t expected_tokens[$];
    int   mismatches;

    function void clear_state();
      in_quoted    = 1'b0;
      quote_held   = 1'b0;
      quote_closed = 1'b0;
      field_open   = 1'b0;
      row_open     = 1'b0;
      skip_lf      = 1'b0;
      saw_row      = 1'b0;
      halted       = 1'b0;
    endfunction

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void emit(logic [2:0] kind, logic [7:0] b, logic [2:0] err);
      out_t r;
      r.out_kind = kind;
      r.out_byte = b;
      r.err_code = err;
      r.run_last = 1'b0;
      if (beat_tokens.size() < MAX_RES) beat_tokens.insert(beat_tokens.size(), r);
    endfunction

    function void flag_error(logic [2:0] code);
      emit(KIND_ERR, 8'h00, code);
      halted = 1'b1;
    endfunction

    // byte outside a quoted field
    function void take_plain(logic [7:0] b);
      if (quote_closed && b != CH_COMMA && b != CH_CR && b != CH_LF) begin
        flag_error(ERR_AFTER_CLOSE);
        return;
      end
      if (b == CH_QUOTE) begin
        if (field_open) begin
          flag_error(ERR_STRAY_QUOTE);
        end else begin
          in_quoted  = 1'b1;
          field_open = 1'b1;
        end
      end else if (b == CH_COMMA) begin
        emit(KIND_FIELD, 8'h00, ERR_NONE);
        row_open     = 1'b1;
        field_open   = 1'b0;
        quote_closed = 1'b0;
      end else if (b == CH_LF || b == CH_CR) begin
        emit(KIND_ROW, 8'h00, ERR_NONE);
        saw_row      = 1'b1;
        row_open     = 1'b0;
        field_open   = 1'b0;
        quote_closed = 1'b0;
        skip_lf      = (b == CH_CR);
      end else begin
        emit(KIND_BYTE, b, ERR_NONE);
        field_open = 1'b1;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      if (halted) return;
      // lf right after cr belongs to the same row end
      if (skip_lf) begin
        skip_lf = 1'b0;
        if (b == CH_LF) return;
      end
      // quote seen inside quotes: doubled quote or closing quote
      if (quote_held) begin
        quote_held = 1'b0;
        if (b == CH_QUOTE) begin
          emit(KIND_BYTE, CH_QUOTE, ERR_NONE);
          return;
        end
        in_quoted    = 1'b0;
        quote_closed = 1'b1;
        take_plain(b);
        return;
      end
      if (in_quoted) begin
        if (b == CH_QUOTE) quote_held = 1'b1;
        else emit(KIND_BYTE, b, ERR_NONE);
        return;
      end
      take_plain(b);
    endfunction

    // end of stream: flush the open row, report errors, back to reset
    function void close_stream();
      if (!halted) begin
        if (quote_held) begin
          quote_held   = 1'b0;
          in_quoted    = 1'b0;
          quote_closed = 1'b1;
        end
        if (in_quoted) begin
          flag_error(ERR_UNTERM);
        end else begin
          if (row_open || field_open) begin
            emit(KIND_ROW, 8'h00, ERR_NONE);
            saw_row = 1'b1;
          end
          if (!saw_row) flag_error(ERR_EMPTY);
        end
      end
      emit(KIND_END, 8'h00, ERR_NONE);
      clear_state();
    endfunction

    function void note_beat(in_t beat);
      out_t r;
      beat_tokens.delete();
      if (beat.in_valid) take_byte(beat.in_byte);
      if (beat.in_end) close_stream();
      foreach (beat_tokens[i]) begin
        r = beat_tokens[i];
        r.run_last = (i == beat_tokens.size() - 1);
        expected_tokens.insert(expected_tokens.size(), r);
      end
    endfunction

    function void check_token(out_t got);
      out_t want;
      if (expected_tokens.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind=%0d byte=%02h err=%0d last=%0b",
                   got.out_kind, got.out_byte, got.err_code, got.run_last);
        mismatches++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.out_kind != want.out_kind || got.out_byte != want.out_byte ||
          got.err_code != want.err_code || got.run_last != want.run_last) begin
        if (mismatches < 10)
          $display({"mismatch: exp kind=%0d byte=%02h err=%0d last=%0b,",
                    " got kind=%0d byte=%02h err=%0d last=%0b"},
                   want.out_kind, want.out_byte, want.err_code, want.run_last,
                   got.out_kind, got.out_byte, got.err_code, got.run_last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  tok_scoreboard board = new();
  int          cycle_cnt  = 0;
  int          burst_left = 0;
  int          items_sent = 0;
  int          stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic [7:0]  text_q[$];

  csv_field_tokenizer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // receiver stall pattern, switching to a random mode whenever its countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (cycle_cnt % 8 < 3);
      default:        out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // beat monitor on both channels, values seen before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_beat(in_data);
      if (out_valid && !out_stall) board.check_token(out_data);
    end
  end

  // sender in bursts with random gaps; valid stays high across a burst
  task automatic send_beat(input in_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (beat.in_valid || beat.in_end) items_sent++;
  endtask

  task automatic send_end();
    in_t beat;
    beat.in_byte  = 8'($urandom_range(0, 255));
    beat.in_valid = 1'b0;
    beat.in_end   = 1'b1;
    send_beat(beat);
  endtask

  // send the buffered text, with an occasional empty beat mixed in
  task automatic flush_text(input bit end_last);
    in_t beat;
    foreach (text_q[i]) begin
      if ($urandom_range(0, 11) == 0) begin
        beat.in_byte  = 8'($urandom_range(0, 255));
        beat.in_valid = 1'b0;
        beat.in_end   = 1'b0;
        send_beat(beat);
      end
      beat.in_byte  = text_q[i];
      beat.in_valid = 1'b1;
      beat.in_end   = end_last && (i == text_q.size() - 1);
      send_beat(beat);
    end
    text_q.delete();
  endtask

  // append one byte to the text buffer
  function automatic void put_char(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 3))
      0:       return CH_QUOTE;
      1:       return CH_COMMA;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // one field, quoted or bare, with random content
  task automatic add_field();
    int n;
    n = $urandom_range(0, 3);
    if ($urandom_range(0, 1)) begin
      put_char(CH_QUOTE);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: begin
            put_char(CH_QUOTE);
            put_char(CH_QUOTE);
          end
          1:       put_char(CH_COMMA);
          2:       put_char(CH_CR);
          3:       put_char(CH_LF);
          default: put_char(pick_plain());
        endcase
      end
      put_char(CH_QUOTE);
    end else begin
      repeat (n) put_char(pick_plain());
    end
  endtask

  // mostly well-formed csv, some corrupted, some noise, rarely empty
  task automatic send_random_stream();
    int  rows, fields;
    bit  end_last;
    if ($urandom_range(0, 19) == 0) begin
      send_end();
      return;
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 10))
        put_char($urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255)));
    end else begin
      rows = $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
        fields = $urandom_range(1, 3);
        for (int f = 0; f < fields; f++) begin
          if (f > 0) put_char(CH_COMMA);
          add_field();
        end
        if (r < rows - 1 || $urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 2))
            0: put_char(CH_LF);
            1: put_char(CH_CR);
            default: begin
              put_char(CH_CR);
              put_char(CH_LF);
            end
          endcase
        end
      end
      if (text_q.size() > 0 && $urandom_range(0, 5) == 0)
        text_q.insert($urandom_range(0, text_q.size() - 1), pick_special());
    end
    end_last = (text_q.size() > 0) && ($urandom_range(0, 1) == 1);
    flush_text(end_last);
    if (!end_last) send_end();
  endtask

  initial begin
    in_t idle_beat;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty input, then a beat with neither byte nor end
    send_end();
    idle_beat = '0;
    send_beat(idle_beat);
    // doubled quotes inside a quoted field, cr lf, last byte with end
    add_str("\"\"\"\",");
    put_char(CH_CR);
    put_char(CH_LF);
    add_str("x");
    flush_text(1'b1);
    // text after closing quote, later bytes dropped
    add_str("\"q\"zw");
    flush_text(1'b1);
    // stray quote in a bare field
    add_str("a\"b");
    flush_text(1'b1);
    // quote still open at end
    add_str("\"ab");
    flush_text(1'b1);
    // closing quote pending at end
    add_str("\"x\"");
    flush_text(1'b1);
    // byte extremes, lone lf and lone cr
    put_char(8'hFF);
    put_char(8'h00);
    put_char(CH_LF);
    put_char(CH_CR);
    flush_text(1'b1);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) send_random_stream();
    in_valid <= 1'b0;

    // let the monitor note the last beat before waiting on the expected queue
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("csv_field_tokenizer_unit_tb: clean");
    end else begin
      $display("csv_field_tokenizer_unit_tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("csv_field_tokenizer_unit_tb: errors");
    $finish;
  end

endmodule
